FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker module of the hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/sha256_pkg.sv
// Package with the shared types and constants of the SHA-256 stream hasher.
`default_nettype none

package sha256_pkg;

    // Source of the byte pushed into the block buffer.
    typedef enum logic [1:0] {
        BYTE_MSG,
        BYTE_PAD,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      push;
        byte_sel_t byte_sel;
        logic      count_bits;
        logic      load_work;
        logic      round;
        logic [5:0] round_idx;
        logic      fold;
        logic      init;
        logic [1:0] word_sel;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;
    } status_t;

    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [5:0] FILL_LEN_POS = 6'd56;
    localparam logic [5:0] ROUND_LAST   = 6'd63;
    localparam logic [1:0] WORD_LAST    = 2'd3;
    localparam logic [7:0] PAD_BYTE     = 8'h80;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

FILE: rtl/sha256_if.sv
// Stream interfaces for message bytes in and digest words out.
`default_nettype none

// Message byte channel.
interface sha256_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output msg_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink (input valid, input msg_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

// Digest word channel.
interface sha256_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/sha256_stream_hasher_top.sv
// SHA-256 stream hasher top level.
// The msg channel takes one transaction per message byte: msg_byte is used
// when has_byte is set, and end_of_message closes the message (a byte in the
// same transaction is absorbed first; has_byte low gives an empty end marker).
// The digest channel then delivers four 64-bit transactions, most significant
// word first, word_index 0 to 3, with last_word set on the fourth.
// A byte that does not complete a 64-byte block is absorbed while msg stays
// ready. The byte that completes a block starts a compression, one round per
// cycle through a single round unit, then a fold of the result into the
// chaining words; msg is not ready meanwhile. At the end of a message,
// padding is written one byte per cycle outside the compressions (one or two
// of them), then the digest words are shown. msg stays not ready while
// digest words are pending; a stalled receiver just holds the current word.
// After the fourth word is taken, the block starts a new message. Reset loads
// the initial hash values and clears the fill index and bit count; it takes
// effect at once, with no clearing pass.
`default_nettype none

module sha256_stream_hasher_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    sha256_msg_if.sink      msg,
    sha256_digest_if.source digest
);

    sha256_pkg::cmd_t    cmd;
    sha256_pkg::status_t status;
    logic [1:0]          word_idx;

    sha256_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (msg.valid),
        .in_has_byte (msg.has_byte),
        .in_eom      (msg.end_of_message),
        .in_ready    (msg.ready),
        .out_valid   (digest.valid),
        .out_ready   (digest.ready),
        .word_idx    (word_idx),
        .status      (status),
        .cmd         (cmd)
    );

    sha256_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_byte    (msg.msg_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest.digest_word)
    );

    assign digest.word_index = word_idx;
    assign digest.last_word  = (word_idx == sha256_pkg::WORD_LAST);

endmodule

`default_nettype wire

FILE: rtl/sha256_dp.sv
// Datapath: byte packing, message schedule window, round logic and chaining words.
`default_nettype none

module sha256_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         msg_byte,
    input  wire sha256_pkg::cmd_t   cmd,
    output sha256_pkg::status_t     status,
    output logic [63:0]             digest_word
);

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    logic [5:0]  fill_reg;
    logic [63:0] bitlen_reg;
    logic [31:0] chain_reg [8];
    logic [23:0] acc_reg;
    logic [31:0] win_reg [16];
    logic [31:0] work_reg [8];

    logic [7:0]  push_byte;
    logic [31:0] new_w;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] shift_in;
    logic        win_shift;

    // Byte source for the buffer: message, pad marker, zero fill or length.
    always_comb
    begin
        unique case (cmd.byte_sel)
            sha256_pkg::BYTE_MSG:  push_byte = msg_byte;
            sha256_pkg::BYTE_PAD:  push_byte = sha256_pkg::PAD_BYTE;
            sha256_pkg::BYTE_ZERO: push_byte = 8'd0;
            sha256_pkg::BYTE_LEN:  push_byte = bitlen_reg[{~fill_reg[2:0], 3'b000} +: 8];
            default:               push_byte = 8'd0;
        endcase
    end

    // One compression round and the next schedule word.
    always_comb
    begin
        ch    = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj   = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]);
        t1    = work_reg[7] + bsig1(work_reg[4]) + ch
              + sha256_pkg::ROUND_K[cmd.round_idx] + win_reg[0];
        t2    = bsig0(work_reg[0]) + maj;
        new_w = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    end

    // The window shifts when a word is packed or when a round consumes one.
    assign win_shift = cmd.round || (cmd.push && (fill_reg[1:0] == 2'd3));
    assign shift_in  = cmd.round ? new_w : {acc_reg, push_byte};

    // Control state: fill index, bit count and chaining words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            bitlen_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha256_pkg::INIT_H[i];
            end
        end
        else
        begin
            if (cmd.init)
            begin
                fill_reg   <= '0;
                bitlen_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= sha256_pkg::INIT_H[i];
                end
            end
            else
            begin
                if (cmd.push)
                begin
                    fill_reg <= fill_reg + 6'd1;
                end
                if (cmd.count_bits)
                begin
                    bitlen_reg <= bitlen_reg + 64'd8;
                end
                if (cmd.fold)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                end
            end
        end
    end

    // Payload: byte packer, schedule window and working variables.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            acc_reg <= {acc_reg[15:0], push_byte};
        end
        if (win_shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= shift_in;
        end
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    assign status.fill = fill_reg;
    assign digest_word = {chain_reg[{cmd.word_sel, 1'b0}], chain_reg[{cmd.word_sel, 1'b1}]};

endmodule

`default_nettype wire

FILE: rtl/sha256_ctrl.sv
// Controller: sequences byte intake, padding, rounds and digest output.
`default_nettype none

module sha256_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_has_byte,
    input  wire logic                in_eom,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               word_idx,
    input  wire sha256_pkg::status_t status,
    output sha256_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_ZERO,
        S_LEN,
        S_ROUND,
        S_FOLD,
        S_OUT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    state_t     after_reg;
    state_t     after_next;
    logic [5:0] rnd_reg;
    logic [5:0] rnd_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [1:0] word_idx_reg;
    logic [1:0] word_idx_next;
    logic       block_end;

    assign block_end = (status.fill == sha256_pkg::FILL_LAST);

    // Next-state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        rnd_next       = rnd_reg;
        out_valid_next = out_valid_reg;
        word_idx_next  = word_idx_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.byte_sel   = sha256_pkg::BYTE_MSG;
        cmd.round_idx  = rnd_reg;
        cmd.word_sel   = word_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_has_byte)
                    begin
                        cmd.push       = 1'b1;
                        cmd.count_bits = 1'b1;
                    end
                    if (in_has_byte && block_end)
                    begin
                        cmd.load_work = 1'b1;
                        state_next    = S_ROUND;
                        after_next    = in_eom ? S_PAD80 : S_IDLE;
                    end
                    else if (in_eom)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_PAD80:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = sha256_pkg::BYTE_PAD;
                if (block_end)
                begin
                    cmd.load_work = 1'b1;
                    state_next    = S_ROUND;
                    after_next    = S_ZERO;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (status.fill == sha256_pkg::FILL_LEN_POS)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.byte_sel = sha256_pkg::BYTE_ZERO;
                    if (block_end)
                    begin
                        cmd.load_work = 1'b1;
                        state_next    = S_ROUND;
                        after_next    = S_ZERO;
                    end
                end
            end
            S_LEN:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = sha256_pkg::BYTE_LEN;
                if (block_end)
                begin
                    cmd.load_work = 1'b1;
                    state_next    = S_ROUND;
                    after_next    = S_OUT;
                end
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == sha256_pkg::ROUND_LAST)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = after_reg;
                if (after_reg == S_OUT)
                begin
                    out_valid_next = 1'b1;
                    word_idx_next  = '0;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (word_idx_reg == sha256_pkg::WORD_LAST)
                    begin
                        cmd.init       = 1'b1;
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        word_idx_next = word_idx_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            after_reg     <= S_IDLE;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
            word_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
            word_idx_reg  <= word_idx_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign word_idx  = word_idx_reg;

endmodule

`default_nettype wire

FILE: rtl/sha256_checker.sv
// Port-level checker for the hasher and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module sha256_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] digest_word,
    input wire logic [1:0]  word_index,
    input wire logic        last_word
);

    // A stalled digest transaction holds its payload.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index))

    // No message byte is taken while digest words are pending.
    `ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)

    // The last flag marks exactly the fourth word.
    `ASSERT_IMPLY(a_last_flag, clk, rst_n, out_valid, last_word == (word_index == 2'd3))

    // Words follow in order without gaps.
    `ASSERT_NEXT(a_word_order, clk, rst_n, out_valid && out_ready && !last_word, out_valid && (word_index == $past(word_index) + 2'd1))

    // Nothing more is shown once the last word has been taken.
    `ASSERT_NEXT(a_digest_done, clk, rst_n, out_valid && out_ready && last_word, !out_valid)

endmodule

bind sha256_stream_hasher_top sha256_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (msg.ready),
    .out_valid   (digest.valid),
    .out_ready   (digest.ready),
    .digest_word (digest.digest_word),
    .word_index  (digest.word_index),
    .last_word   (digest.last_word)
);

`default_nettype wire

FILE: tb/sv/sha256_stream_hasher_top_tb.sv
// Self-checking testbench for the SHA-256 stream hasher top level.

// One digest word as the digest channel should deliver it.
typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic        last;
} digest_beat_t;

// Tracks the hash state of the message in flight and checks the digest words.
class sha256_digest_scoreboard;
    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam int         LENGTH_SLOT = 56;
    localparam int         BLOCK_BYTES = 64;
    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]  hash_words [8];
    logic [7:0]   block_bytes [64];
    int           fill;
    logic [63:0]  message_bits;
    digest_beat_t expected_words [$];
    int           mismatches;

    function new();
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        foreach (hash_words[i])
            hash_words[i] = START_HASH[i];
        foreach (block_bytes[i])
            block_bytes[i] = 8'h00;
        fill = 0;
        message_bits = 64'd0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Runs the 64 rounds over the full block and folds into the hash words.
    function void compress();
        logic [31:0] sched [64];
        logic [31:0] wv [8];
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
        end
        wv = hash_words;
        for (int i = 0; i < 64; i++)
        begin
            t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
                 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + ROUND_CONST[i] + sched[i];
            t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
                 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
            wv[7] = wv[6];
            wv[6] = wv[5];
            wv[5] = wv[4];
            wv[4] = wv[3] + t1;
            wv[3] = wv[2];
            wv[2] = wv[1];
            wv[1] = wv[0];
            wv[0] = t1 + t2;
        end
        foreach (hash_words[i])
            hash_words[i] = hash_words[i] + wv[i];
    endfunction

    function void push_byte(logic [7:0] b);
        block_bytes[fill] = b;
        fill++;
        if (fill == BLOCK_BYTES)
        begin
            compress();
            fill = 0;
        end
    endfunction

    // Notes one accepted message transaction and queues the digest it closes.
    function void absorb(logic [7:0] b, logic has_byte, logic end_of_message);
        logic [63:0]  length_bits;
        digest_beat_t beat;
        if (has_byte)
        begin
            push_byte(b);
            message_bits = message_bits + 64'd8;
        end
        if (!end_of_message)
            return;
        length_bits = message_bits;
        push_byte(PAD_MARK);
        while (fill != LENGTH_SLOT)
            push_byte(8'h00);
        for (int k = 0; k < 8; k++)
            push_byte(length_bits[63 - 8*k -: 8]);
        for (int k = 0; k < 4; k++)
        begin
            beat.word  = {hash_words[2*k], hash_words[2*k+1]};
            beat.index = k[1:0];
            beat.last  = (k == 3);
            expected_words.push_back(beat);
        end
        restart();
    endfunction

    // Compares one accepted digest transaction with the oldest expected word.
    function void check_word(logic [63:0] word, logic [1:0] index, logic last);
        digest_beat_t want;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected digest word %h index %0d last %0b",
                     $time, word, index, last);
            mismatches++;
            return;
        end
        want = expected_words.pop_front();
        if (word !== want.word)
        begin
            $display("%0t: digest_word expected %h actual %h", $time, want.word, word);
            mismatches++;
        end
        if (index !== want.index)
        begin
            $display("%0t: word_index expected %0d actual %0d", $time, want.index, index);
            mismatches++;
        end
        if (last !== want.last)
        begin
            $display("%0t: last_word expected %0b actual %0b", $time, want.last, last);
            mismatches++;
        end
    endfunction
endclass

module sha256_stream_hasher_top_tb;
    localparam int RESET_CYCLES  = 7;
    localparam int TARGET_ITEMS  = 360;
    localparam int PHASE_ITEMS   = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 250;
    localparam int STALL_LIMIT   = 3000;

    logic clk = 1'b0;
    logic rst_n;

    sha256_msg_if    msg_ch ();
    sha256_digest_if digest_ch ();

    sha256_stream_hasher_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (digest_ch)
    );

    sha256_digest_scoreboard digests = new();

    int  items_sent     = 0;
    int  send_idle_pct  = 31;
    int  recv_idle_pct  = 65;
    bit  hold_requested = 1'b0;
    bit  hold_done      = 1'b0;
    int  hold_left      = 0;

    // Free-running clock.
    always #5 clk = ~clk;

    // Offers one message transaction, with random idle cycles before it.
    task automatic send_item(logic [7:0] b, logic has_byte, logic end_of_message);
        if (items_sent < PHASE_ITEMS)
        begin
            send_idle_pct = 31;
            recv_idle_pct = 65;
        end
        else if (items_sent < 2 * PHASE_ITEMS)
        begin
            send_idle_pct = 65;
            recv_idle_pct = 31;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid          <= 1'b1;
        msg_ch.msg_byte       <= b;
        msg_ch.has_byte       <= has_byte;
        msg_ch.end_of_message <= end_of_message;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        digests.absorb(b, has_byte, end_of_message);
        if (has_byte || end_of_message)
            items_sent++;
    endtask

    // Sends a message of random bytes, closed on its last byte or by an empty marker.
    task automatic send_message(int length, bit close_on_byte);
        for (int i = 0; i < length; i++)
        begin
            if ($urandom_range(0, 99) < 5)
                send_item(8'($urandom), 1'b0, 1'b0);
            if (i == length - 1 && close_on_byte)
            begin
                if (items_sent >= 2 * PHASE_ITEMS && !hold_done)
                begin
                    hold_requested = 1'b1;
                    hold_done      = 1'b1;
                end
                send_item(8'($urandom), 1'b1, 1'b1);
            end
            else
                send_item(8'($urandom), 1'b1, 1'b0);
        end
        if (length == 0 || !close_on_byte)
        begin
            if (items_sent >= 2 * PHASE_ITEMS && !hold_done)
            begin
                hold_requested = 1'b1;
                hold_done      = 1'b1;
            end
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Digest receiver: checks each transaction and throttles ready.
    initial
    begin : digest_receiver
        digest_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (digest_ch.valid && digest_ch.ready)
                digests.check_word(digest_ch.digest_word, digest_ch.word_index,
                                   digest_ch.last_word);
            if (hold_requested)
            begin
                hold_left      = HOLD_CYCLES;
                hold_requested = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                digest_ch.ready <= 1'b0;
            end
            else
                digest_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run if no transaction moves for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((msg_ch.valid && msg_ch.ready) || (digest_ch.valid && digest_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Reset, stimulus and final verdict.
    initial
    begin : stimulus
        rst_n                 <= 1'b0;
        msg_ch.valid          <= 1'b0;
        msg_ch.msg_byte       <= 8'h00;
        msg_ch.has_byte       <= 1'b0;
        msg_ch.end_of_message <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Empty message: end marker alone, with a byte that must be ignored.
        send_item(8'hFF, 1'b0, 1'b1);
        // Idle transaction, then a one-byte message closed on its own byte.
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        // Zero bytes closed by a separate empty marker, with an idle in between.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // The classic "abc" message, closed on the last byte.
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);

        // Padding boundaries: length field fits, spills, pad mark fills, full block.
        send_message(55, $urandom_range(0, 1));
        send_message(56, $urandom_range(0, 1));
        send_message(63, $urandom_range(0, 1));
        send_message(64, $urandom_range(0, 1));

        // Random messages, mostly short, some near or past one block.
        while (items_sent < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_message($urandom_range(0, 24), $urandom_range(0, 1));
                5:             send_message(55, $urandom_range(0, 1));
                6:             send_message(56, $urandom_range(0, 1));
                7:             send_message($urandom_range(63, 64), $urandom_range(0, 1));
                8:             send_message($urandom_range(50, 70), $urandom_range(0, 1));
                default:       send_message($urandom_range(100, 130), $urandom_range(0, 1));
            endcase
        end
        msg_ch.valid <= 1'b0;

        // Drain the outstanding digest words, then allow trailing cycles.
        while (digests.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (digests.mismatches == 0 && digests.expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
